/* rtl/core/log_domain_agc_loop_macros.svh */
// assertion macros for the log-domain agc loop
// used by the port checker; no other dependencies
`ifndef LOG_DOMAIN_AGC_LOOP_MACROS_SVH
`define LOG_DOMAIN_AGC_LOOP_MACROS_SVH

// clocked assertion, disabled while reset is high
`define LDAGC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LDAGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ldagc_pkg.sv */
// shared types and constants for the log-domain agc loop
// no dependencies
`timescale 1ns / 1ps

package ldagc_pkg;

  localparam int GAIN_BITS  = 6;
  localparam int LVL_BITS   = 8;
  localparam int ERR_BITS   = 9;
  localparam int OUTL_BITS  = 9;
  localparam int DB_BITS    = 4;
  localparam int ALPHA_BITS = 10;
  localparam int FRAC_BITS  = 10;
  localparam int FG_BITS    = GAIN_BITS + FRAC_BITS;

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET_DB   = 6'd24;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET_Q10 = 10'd819;

  // register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_TARGET   = 3'd1;
  localparam logic [2:0] REG_DEADBAND = 3'd2;
  localparam logic [2:0] REG_BLANKLIM = 3'd3;
  localparam logic [2:0] REG_ALPHA    = 3'd4;
  localparam logic [2:0] REG_READBACK = 3'd5;

  typedef struct packed {
    logic                         enable_loop;
    logic signed [LVL_BITS-1:0]   target_level_dbfs;
    logic [DB_BITS-1:0]           deadband_db;
    logic [DB_BITS-1:0]           blank_count_limit;
    logic [ALPHA_BITS-1:0]        loop_coefficient_q10;
    logic                         readback_in_use;
  } cfg_t;

  typedef struct packed {
    logic clear_blank;
  } cfg_ctl_t;

endpackage

/* rtl/core/ldagc_front.sv */
// front end: accepts input beats and classifies them for the back end
// depends on ldagc_pkg
`timescale 1ns / 1ps

module ldagc_front import ldagc_pkg::*; #(
  parameter int MAG_BITS    = 16,
  parameter int GAIN_MAX_DB = 46,
  parameter int ENTRY_BITS  = MAG_BITS + LVL_BITS + GAIN_BITS + ERR_BITS + 1
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MAG_BITS-1:0]         raw_magnitude,
  input  logic signed [LVL_BITS-1:0]  level_dbfs,
  input  logic [GAIN_BITS-1:0]        readback_gain_db,
  input  cfg_t                        cfg,
  input  logic                        q_full,
  output logic                        push,
  output logic [ENTRY_BITS-1:0]       entry
);

  logic signed [ERR_BITS-1:0] err;
  logic                       resync;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // the user must change target only while idle, which the block does not enforce; the error is formed here
  assign err = ERR_BITS'(cfg.target_level_dbfs) - ERR_BITS'(level_dbfs);
  assign resync = cfg.readback_in_use &&
                  (readback_gain_db <= GAIN_BITS'(GAIN_MAX_DB));

  assign entry = {raw_magnitude, level_dbfs, readback_gain_db, err, resync};

endmodule

/* rtl/core/ldagc_queue.sv */
// two-entry queue between front and back end
// depends on nothing but its width parameter
`timescale 1ns / 1ps

module ldagc_queue #(
  parameter int WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/ldagc_back.sv */
// back end: loop state, gain update and output register
// depends on ldagc_pkg
`timescale 1ns / 1ps

module ldagc_back import ldagc_pkg::*; #(
  parameter int MAG_BITS    = 16,
  parameter int GAIN_MAX_DB = 46,
  parameter int ENTRY_BITS  = MAG_BITS + LVL_BITS + GAIN_BITS + ERR_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  cfg_ctl_t                    ctl,
  input  logic                        q_valid,
  input  logic [ENTRY_BITS-1:0]       q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [GAIN_BITS-1:0]        gain_db,
  output logic                        gain_write,
  output logic                        loop_ran,
  output logic signed [OUTL_BITS-1:0] level_before_amp_dbfs
);

  localparam int SUM_BITS  = FG_BITS + 5;
  localparam int PROD_BITS = ALPHA_BITS + 1 + ERR_BITS;
  localparam logic signed [SUM_BITS-1:0] FG_MAX =
    SUM_BITS'(GAIN_MAX_DB * (1 << FRAC_BITS));
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = GAIN_BITS'(GAIN_MAX_DB);

  logic [MAG_BITS-1:0]         last_magnitude;
  logic [DB_BITS-1:0]          blank_counter;
  logic                        gain_changed_mark;
  logic [GAIN_BITS-1:0]        integer_gain;
  logic [FG_BITS-1:0]          filtered_gain_q10;
  logic signed [OUTL_BITS-1:0] last_input_level;

  logic [MAG_BITS-1:0]         e_mag;
  logic signed [LVL_BITS-1:0]  e_lvl;
  logic [GAIN_BITS-1:0]        e_rb;
  logic signed [ERR_BITS-1:0]  e_err;
  logic                        e_resync;

  logic                        run;
  logic                        allowed;
  logic [GAIN_BITS-1:0]        g0;
  logic signed [ERR_BITS-1:0]  err_rail;
  logic [ERR_BITS-1:0]         mag_err;
  logic signed [ERR_BITS-1:0]  err_fin;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [SUM_BITS-1:0]  sum;
  logic [FG_BITS-1:0]          fg_next;
  logic [GAIN_BITS-1:0]        gain_next;
  logic signed [OUTL_BITS-1:0] level_next;

  assign {e_mag, e_lvl, e_rb, e_err, e_resync} = q_data;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    run      = cfg.enable_loop && (e_mag != last_magnitude);
    g0       = e_resync ? e_rb : integer_gain;
    allowed  = run && (!gain_changed_mark || (blank_counter >= cfg.blank_count_limit));

    // no push past the rails
    err_rail = e_err;
    if (g0 == GAIN_MAX) begin
      if (e_err > 0) err_rail = '0;
    end else if (g0 == '0) begin
      if (e_err < 0) err_rail = '0;
    end
    mag_err = err_rail[ERR_BITS-1] ? ERR_BITS'(-err_rail) : ERR_BITS'(err_rail);
    err_fin = (mag_err <= ERR_BITS'(cfg.deadband_db)) ? '0 : err_rail;

    prod = $signed({1'b0, cfg.loop_coefficient_q10}) * err_fin;
    sum  = $signed({5'b0, filtered_gain_q10}) + SUM_BITS'(prod);
    if (sum > FG_MAX) begin
      fg_next = FG_BITS'(FG_MAX);
    end else if (sum < 0) begin
      fg_next = '0;
    end else begin
      fg_next = FG_BITS'(sum);
    end
    gain_next  = fg_next[FG_BITS-1:FRAC_BITS];
    level_next = OUTL_BITS'(e_lvl) - OUTL_BITS'($signed({1'b0, g0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_magnitude    <= '0;
      blank_counter     <= '0;
      gain_changed_mark <= 1'b0;
      integer_gain      <= GAIN_RESET_DB;
      filtered_gain_q10 <= FG_BITS'(GAIN_RESET_DB) << FRAC_BITS;
      last_input_level  <= -OUTL_BITS'(GAIN_RESET_DB);
      out_valid         <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.clear_blank) begin
        blank_counter     <= '0;
        gain_changed_mark <= 1'b0;
      end else if (q_pop && allowed) begin
        blank_counter     <= '0;
        gain_changed_mark <= (err_fin != 0);
      end else if (q_pop && run) begin
        blank_counter <= blank_counter + DB_BITS'(1);
      end
      if (q_pop) begin
        gain_write <= allowed && (err_fin != 0);
        loop_ran   <= allowed;
        if (allowed) begin
          last_magnitude        <= e_mag;
          last_input_level      <= level_next;
          filtered_gain_q10     <= fg_next;
          integer_gain          <= gain_next;
          gain_db               <= gain_next;
          level_before_amp_dbfs <= level_next;
        end else if (run) begin
          integer_gain          <= g0;
          gain_db               <= g0;
          level_before_amp_dbfs <= last_input_level;
        end else begin
          gain_db               <= integer_gain;
          level_before_amp_dbfs <= last_input_level;
        end
      end
    end
  end

endmodule

/* rtl/core/log_domain_agc_loop.sv */
// top level of the log-domain agc loop: register file, front, queue, back
// depends on ldagc_pkg, ldagc_front, ldagc_queue, ldagc_back
//
//  channel   signals                                      beat
//  apb       psel penable pwrite paddr pwdata prdata       one register write or read
//  in        in_valid in_ready + 3 fields                  one magnitude report
//  out       out_valid out_ready + 4 fields                one gain update result
//
// one beat per cycle sustained while out_ready is high; a result passes from the front
// into the two-entry queue, then through the registered update in the back end
// the gain multiply-accumulate and saturate are combinational in the back end
// synchronous reset clears loop state, queue and output valid; no clearing pass
// an output stall fills the queue, then in_ready drops
`timescale 1ns / 1ps

module log_domain_agc_loop import ldagc_pkg::*; #(
  parameter int MAG_BITS    = 16,
  parameter int GAIN_MAX_DB = 46
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MAG_BITS-1:0]         raw_magnitude,
  input  logic signed [LVL_BITS-1:0]  level_dbfs,
  input  logic [GAIN_BITS-1:0]        readback_gain_db,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [GAIN_BITS-1:0]        gain_db,
  output logic                        gain_write,
  output logic                        loop_ran,
  output logic signed [OUTL_BITS-1:0] level_before_amp_dbfs
);

  localparam int ENTRY_BITS = MAG_BITS + LVL_BITS + GAIN_BITS + ERR_BITS + 1;

  cfg_t                  cfg;
  cfg_ctl_t              ctl;
  logic                  wr_en;
  logic [2:0]            wr_idx;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  push;
  logic [ENTRY_BITS-1:0] entry;
  logic [ENTRY_BITS-1:0] q_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_comb begin
    ctl.clear_blank = wr_en && ((wr_idx == REG_BLANKLIM) ||
                      ((wr_idx == REG_ENABLE) && pwdata[0] && !cfg.enable_loop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_loop          <= 1'b0;
      cfg.target_level_dbfs    <= '0;
      cfg.deadband_db          <= DB_BITS'(1);
      cfg.blank_count_limit    <= DB_BITS'(1);
      cfg.loop_coefficient_q10 <= ALPHA_RESET_Q10;
      cfg.readback_in_use      <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_ENABLE:   cfg.enable_loop          <= pwdata[0];
        REG_TARGET:   cfg.target_level_dbfs    <= pwdata[LVL_BITS-1:0];
        REG_DEADBAND: cfg.deadband_db          <= pwdata[DB_BITS-1:0];
        REG_BLANKLIM: cfg.blank_count_limit    <= pwdata[DB_BITS-1:0];
        REG_ALPHA:    cfg.loop_coefficient_q10 <= pwdata[ALPHA_BITS-1:0];
        REG_READBACK: cfg.readback_in_use      <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE:   prdata = {31'b0, cfg.enable_loop};
      REG_TARGET:   prdata = 32'($signed(cfg.target_level_dbfs));
      REG_DEADBAND: prdata = {28'b0, cfg.deadband_db};
      REG_BLANKLIM: prdata = {28'b0, cfg.blank_count_limit};
      REG_ALPHA:    prdata = {22'b0, cfg.loop_coefficient_q10};
      REG_READBACK: prdata = {31'b0, cfg.readback_in_use};
      default:      prdata = '0;
    endcase
  end

  ldagc_front #(
    .MAG_BITS    (MAG_BITS),
    .GAIN_MAX_DB (GAIN_MAX_DB),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_magnitude    (raw_magnitude),
    .level_dbfs       (level_dbfs),
    .readback_gain_db (readback_gain_db),
    .cfg              (cfg),
    .q_full           (q_full),
    .push             (push),
    .entry            (entry)
  );

  ldagc_queue #(
    .WIDTH (ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  ldagc_back #(
    .MAG_BITS    (MAG_BITS),
    .GAIN_MAX_DB (GAIN_MAX_DB),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk                   (clk),
    .rst                   (rst),
    .cfg                   (cfg),
    .ctl                   (ctl),
    .q_valid               (q_valid),
    .q_data                (q_data),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .gain_db               (gain_db),
    .gain_write            (gain_write),
    .loop_ran              (loop_ran),
    .level_before_amp_dbfs (level_before_amp_dbfs)
  );

endmodule

/* rtl/core/ldagc_checker.sv */
// port-level checker for the log-domain agc loop, bound to the top level
// depends on ldagc_pkg and log_domain_agc_loop_macros.svh
`timescale 1ns / 1ps
`include "log_domain_agc_loop_macros.svh"

module ldagc_checker import ldagc_pkg::*; #(
  parameter int GAIN_MAX_DB = 46
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [GAIN_BITS-1:0]        gain_db,
  input logic                        gain_write,
  input logic                        loop_ran,
  input logic signed [OUTL_BITS-1:0] level_before_amp_dbfs
);

  // a stalled result beat holds
  `LDAGC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(gain_db) && $stable(level_before_amp_dbfs), "stalled result beat changed")

  // a gain write only comes from an evaluated update
  `LDAGC_ASSERT(a_write_needs_run, clk, rst, out_valid && gain_write |-> loop_ran, "gain write without loop run")

  // gain never leaves its rails
  `LDAGC_ASSERT(a_gain_range, clk, rst, out_valid |-> gain_db <= GAIN_BITS'(GAIN_MAX_DB), "gain above maximum")

  // no result beat right after reset
  `LDAGC_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result beat after reset")

endmodule

bind log_domain_agc_loop ldagc_checker #(
  .GAIN_MAX_DB (GAIN_MAX_DB)
) u_ldagc_checker (
  .clk                   (clk),
  .rst                   (rst),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .gain_db               (gain_db),
  .gain_write            (gain_write),
  .loop_ran              (loop_ran),
  .level_before_amp_dbfs (level_before_amp_dbfs)
);
